// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SDAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication, disabled while reset is held.
`define SDAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ===== rtl/sdaf_pkg.sv =====
// Shared constants, types and state encoding of the decimal ASCII formatter.
package sdaf_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned PAD_W      = 4;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned MAX_DIGITS = 10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_DOT
    } t_state;

    // Status of the shift-add-3 converter as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_dd_stat;

endpackage

// ===== rtl/sdaf_in_if.sv =====
// Request channel carrying a number and its formatting flags.
interface sdaf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sdaf_pkg::VALUE_W-1:0]  value;
    logic                                 decimal_mode;
    logic                                 pad_mode;
    logic        [sdaf_pkg::PAD_W-1:0]    pad_digits;

    modport source (output valid, output value, output decimal_mode, output pad_mode,
                    output pad_digits, input ready);
    modport sink   (input valid, input value, input decimal_mode, input pad_mode,
                    input pad_digits, output ready);
endinterface

// ===== rtl/sdaf_out_if.sv =====
// Result channel carrying the characters of each request, one ASCII character per transfer.
interface sdaf_out_if;
    logic                          valid;
    logic                          ready;
    logic [sdaf_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/sdaf_dd.sv =====
// Bit-serial binary to BCD converter (shift-add-3), one bit per cycle.
module sdaf_dd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdaf_pkg::VALUE_W-1:0]  i_bin,
    output logic [sdaf_pkg::BCD_W-1:0]    o_bcd,
    output sdaf_pkg::t_dd_stat            o_stat
);

    localparam int unsigned CNT_W = $clog2(sdaf_pkg::VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sdaf_pkg::VALUE_W - 1);

    logic [sdaf_pkg::VALUE_W-1:0] r_bin;
    logic [sdaf_pkg::BCD_W-1:0]   r_bcd;
    logic [sdaf_pkg::BCD_W-1:0]   w_adj;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // Every digit of five or more gets three added before the shift.
    always_comb begin
        for (int k = 0; k < sdaf_pkg::BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {w_adj[sdaf_pkg::BCD_W-2:0], r_bin[sdaf_pkg::VALUE_W-1]};
            r_bin <= {r_bin[sdaf_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    assign o_bcd       = r_bcd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/signed_decimal_ascii_formatter.sv =====
// After a request is accepted, the converter runs its 32 shift steps and the
// sequencer then loads the characters, 1 to 12 of them, into the output register;
// a new request is taken only once the last one of them has been loaded.
// Characters then leave one per cycle while the consumer takes them.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; the data registers are not cleared.
module signed_decimal_ascii_formatter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdaf_in_if.sink    i_in,
    sdaf_out_if.source o_out
);

    // Converter interface. The magnitude is formed on the request edge so the
    // converter starts shifting in the very next cycle.
    logic [sdaf_pkg::VALUE_W-1:0] w_mag;
    logic [sdaf_pkg::BCD_W-1:0]   w_bcd;
    sdaf_pkg::t_dd_stat           w_dd_stat;
    logic                         w_accept;

    // Request attributes kept for the whole emission.
    logic                         r_neg;
    logic                         r_dec;
    logic                         r_pad;
    logic [sdaf_pkg::POS_W-1:0]   r_pad_n;
    logic [sdaf_pkg::POS_W-1:0]   w_pad_n;
    logic                         w_dec_eff;

    // Sequencer.
    sdaf_pkg::t_state             r_state;
    sdaf_pkg::t_state             n_state;
    logic [sdaf_pkg::POS_W-1:0]   r_pos;
    logic [sdaf_pkg::POS_W-1:0]   n_pos;
    logic [sdaf_pkg::POS_W-1:0]   w_top;
    logic [3:0]                   w_dig [sdaf_pkg::BCD_DIGITS];
    logic [sdaf_pkg::CHAR_W-1:0]  w_digit_char;

    // Output register and what the sequencer loads into it.
    logic                         r_out_valid;
    logic [sdaf_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;
    logic                         w_slot;
    logic                         w_emit;
    logic [sdaf_pkg::CHAR_W-1:0]  w_char;
    logic                         w_last;

    assign i_in.ready = (r_state == sdaf_pkg::ST_IDLE) && !w_dd_stat.busy;
    assign w_accept   = i_in.valid && i_in.ready;

    // Two's complement negation; the most negative value maps onto its
    // unsigned magnitude, which the converter handles like any other.
    assign w_mag = i_in.value[sdaf_pkg::VALUE_W-1]
                 ? (sdaf_pkg::VALUE_W'(0) - $unsigned(i_in.value))
                 : $unsigned(i_in.value);

    // A pad width of zero prints one digit, a width above the maximum saturates.
    always_comb begin
        if (i_in.pad_digits == '0) begin
            w_pad_n = sdaf_pkg::POS_W'(1);
        end else if (i_in.pad_digits > sdaf_pkg::PAD_W'(sdaf_pkg::MAX_DIGITS)) begin
            w_pad_n = sdaf_pkg::POS_W'(sdaf_pkg::MAX_DIGITS);
        end else begin
            w_pad_n = i_in.pad_digits;
        end
    end

    sdaf_dd u_dd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_bin   (w_mag),
        .o_bcd   (w_bcd),
        .o_stat  (w_dd_stat)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg   <= i_in.value[sdaf_pkg::VALUE_W-1];
            r_dec   <= i_in.decimal_mode;
            r_pad   <= i_in.pad_mode;
            r_pad_n <= w_pad_n;
        end
    end

    // Padded mode overrides decimal mode.
    assign w_dec_eff = r_dec && !r_pad;

    // Split the BCD word into digits and find the highest nonzero one. Zero
    // still prints one digit, and decimal mode always keeps an integer digit
    // in front of the point.
    always_comb begin
        w_top = sdaf_pkg::POS_W'(1);
        for (int k = 0; k < sdaf_pkg::BCD_DIGITS; k++) begin
            w_dig[k] = w_bcd[4*k +: 4];
            if (w_bcd[4*k +: 4] != 4'd0) begin
                w_top = sdaf_pkg::POS_W'(k + 1);
            end
        end
        if (w_dec_eff && (w_top < sdaf_pkg::POS_W'(2))) begin
            w_top = sdaf_pkg::POS_W'(2);
        end
    end

    // r_pos counts the digits still to print; the digit printed is r_pos - 1.
    assign w_digit_char = sdaf_pkg::ASCII_ZERO
                        + {4'd0, w_dig[r_pos - sdaf_pkg::POS_W'(1)]};

    // The output register can take a character when it is empty or when its
    // current character leaves in this cycle.
    assign w_slot = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdaf_pkg::ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        w_emit  = 1'b0;
        w_char  = sdaf_pkg::ASCII_ZERO;
        w_last  = 1'b0;
        unique case (r_state)
            sdaf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = sdaf_pkg::ST_CONV;
                end
            end
            sdaf_pkg::ST_CONV: begin
                // Wait for the converter, then pick the digit count.
                if (w_dd_stat.done) begin
                    if (r_pad) begin
                        n_pos   = r_pad_n;
                        n_state = sdaf_pkg::ST_DIGIT;
                    end else begin
                        n_pos   = w_top;
                        n_state = r_neg ? sdaf_pkg::ST_SIGN : sdaf_pkg::ST_DIGIT;
                    end
                end
            end
            sdaf_pkg::ST_SIGN: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_char  = sdaf_pkg::ASCII_MINUS;
                    n_state = sdaf_pkg::ST_DIGIT;
                end
            end
            sdaf_pkg::ST_DIGIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = w_digit_char;
                    w_last = (r_pos == sdaf_pkg::POS_W'(1));
                    n_pos  = r_pos - sdaf_pkg::POS_W'(1);
                    if (r_pos == sdaf_pkg::POS_W'(1)) begin
                        n_state = sdaf_pkg::ST_IDLE;
                    end else if (w_dec_eff && (r_pos == sdaf_pkg::POS_W'(2))) begin
                        n_state = sdaf_pkg::ST_DOT;
                    end
                end
            end
            sdaf_pkg::ST_DOT: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_char  = sdaf_pkg::ASCII_DOT;
                    n_state = sdaf_pkg::ST_DIGIT;
                end
            end
            default: begin
                n_state = sdaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule

// ===== rtl/sdaf_checker.sv =====
// Port-level checks of the formatter and their binding to the top level.
`include "assert_macros.svh"

module sdaf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sdaf_pkg::CHAR_W-1:0]   i_char_code,
    input logic                          i_last_char
);

    // A held character must not change while the consumer stalls.
    `SDAF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_char_code) && $stable(i_last_char))

    // The block stays busy right after taking a request.
    `SDAF_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Only digits, the minus sign and the point ever leave the block.
    `SDAF_ASSERT_SAME(a_char_legal, i_clk, i_rst_n, i_out_valid, ((i_char_code >= sdaf_pkg::ASCII_ZERO) && (i_char_code <= sdaf_pkg::ASCII_NINE)) || (i_char_code == sdaf_pkg::ASCII_MINUS) || (i_char_code == sdaf_pkg::ASCII_DOT))

    // A number always ends on a digit.
    `SDAF_ASSERT_SAME(a_last_is_digit, i_clk, i_rst_n, i_out_valid && i_last_char, (i_char_code >= sdaf_pkg::ASCII_ZERO) && (i_char_code <= sdaf_pkg::ASCII_NINE))

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_code (o_out.char_code),
    .i_last_char (o_out.last_char)
);

// ===== tb/sv/signed_decimal_ascii_formatter_tb.sv =====
// Self-checking testbench of the signed decimal ASCII formatter.
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 48;
    localparam int PHASE_NUMBERS  = 45;

    typedef struct packed {
        logic signed [sdaf_pkg::VALUE_W-1:0] value;
        logic                                decimal_mode;
        logic                                pad_mode;
        logic [sdaf_pkg::PAD_W-1:0]          pad_digits;
    } t_number;

    typedef struct packed {
        logic [sdaf_pkg::CHAR_W-1:0] char_code;
        logic                        last_char;
    } t_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdaf_in_if  num_if();
    sdaf_out_if chr_if();

    signed_decimal_ascii_formatter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_if),
        .o_out   (chr_if)
    );

    t_number number_queue[$];
    t_char   expected_chars[$];
    bit      num_held;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    int      numbers_sent;
    int      chars_checked;
    int      mismatches;
    int      idle_cycles;

    always #5 i_clk = ~i_clk;

    // Expected text of one number: the magnitude is split into ten decimal
    // digits, units first, and the characters are picked by mode.
    function automatic void format_number(
        input logic signed [sdaf_pkg::VALUE_W-1:0] value,
        input logic decimal_mode,
        input logic pad_mode,
        input logic [sdaf_pkg::PAD_W-1:0] pad_digits);
        logic [sdaf_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digit [sdaf_pkg::BCD_DIGITS];
        int unsigned                  rest;
        int unsigned                  n;
        logic                         neg;
        t_char                        text[$];
        t_char                        ch;

        neg  = value[sdaf_pkg::VALUE_W-1];
        // The most negative value wraps to itself and reads as 2147483648.
        mag  = neg ? (~value + 1'b1) : value;
        rest = mag;
        for (int k = 0; k < sdaf_pkg::BCD_DIGITS; k++) begin
            digit[k] = 4'(rest % 10);
            rest     = rest / 10;
        end
        ch.last_char = 1'b0;
        if (pad_mode) begin
            // Fixed width, no sign; a width of zero prints one digit and
            // widths past the digit count saturate.
            n = 32'(pad_digits);
            if (n < 1) n = 1;
            if (n > sdaf_pkg::MAX_DIGITS) n = sdaf_pkg::MAX_DIGITS;
            for (int p = n; p > 0; p--) begin
                ch.char_code = sdaf_pkg::ASCII_ZERO + sdaf_pkg::CHAR_W'(digit[p-1]);
                text.push_back(ch);
            end
        end else begin
            n = 1;
            for (int p = 0; p < sdaf_pkg::BCD_DIGITS; p++) begin
                if (digit[p] != 0) n = p + 1;
            end
            // Decimal mode always keeps one integer digit ahead of the point.
            if (decimal_mode && n < 2) n = 2;
            if (neg) begin
                ch.char_code = sdaf_pkg::ASCII_MINUS;
                text.push_back(ch);
            end
            for (int p = n; p > 0; p--) begin
                if (decimal_mode && p == 1) begin
                    ch.char_code = sdaf_pkg::ASCII_DOT;
                    text.push_back(ch);
                end
                ch.char_code = sdaf_pkg::ASCII_ZERO + sdaf_pkg::CHAR_W'(digit[p-1]);
                text.push_back(ch);
            end
        end
        text[text.size()-1].last_char = 1'b1;
        foreach (text[k]) expected_chars.push_back(text[k]);
    endfunction

    task automatic add_number(input logic signed [sdaf_pkg::VALUE_W-1:0] value,
                              input logic decimal_mode,
                              input logic pad_mode,
                              input logic [sdaf_pkg::PAD_W-1:0] pad_digits);
        t_number num;
        num.value        = value;
        num.decimal_mode = decimal_mode;
        num.pad_mode     = pad_mode;
        num.pad_digits   = pad_digits;
        number_queue.push_back(num);
    endtask

    // Returns once every queued number has been taken and all its text seen.
    task automatic wait_for_text_done();
        while (number_queue.size() != 0 || num_held || expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: presents the next queued number when the slot is free.
    always @(posedge i_clk) begin : drive_numbers
        t_number next_num;
        if (!i_rst_n) begin
            num_if.valid        <= 1'b0;
            num_if.value        <= '0;
            num_if.decimal_mode <= 1'b0;
            num_if.pad_mode     <= 1'b0;
            num_if.pad_digits   <= '0;
            num_held             = 1'b0;
            numbers_sent         = 0;
        end else begin
            if (num_if.valid && num_if.ready) begin
                format_number(num_if.value, num_if.decimal_mode, num_if.pad_mode,
                              num_if.pad_digits);
                numbers_sent++;
                num_held = 1'b0;
            end
            if (!num_if.valid || num_if.ready) begin
                if (number_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_num            = number_queue.pop_front();
                    num_held            = 1'b1;
                    num_if.valid        <= 1'b1;
                    num_if.value        <= next_num.value;
                    num_if.decimal_mode <= next_num.decimal_mode;
                    num_if.pad_mode     <= next_num.pad_mode;
                    num_if.pad_digits   <= next_num.pad_digits;
                end else begin
                    num_if.valid <= 1'b0;
                end
            end
        end
    end

    // Character receiver with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chr_if.ready <= 1'b0;
        end else begin
            chr_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Character monitor: each accepted character is checked against the oldest one due.
    always @(posedge i_clk) begin : check_chars
        t_char due;
        if (!i_rst_n) begin
            chars_checked = 0;
            mismatches    = 0;
        end else if (chr_if.valid && chr_if.ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character 0x%02h (last_char %0b)",
                       chr_if.char_code, chr_if.last_char);
                mismatches++;
            end else begin
                due = expected_chars.pop_front();
                chars_checked++;
                if (chr_if.char_code !== due.char_code) begin
                    $error("char_code mismatch: expected 0x%02h, got 0x%02h",
                           due.char_code, chr_if.char_code);
                    mismatches++;
                end
                if (chr_if.last_char !== due.last_char) begin
                    $error("last_char mismatch: expected %0b, got %0b",
                           due.last_char, chr_if.last_char);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or character.
    always @(posedge i_clk) begin
        if (!i_rst_n || (num_if.valid && num_if.ready) || (chr_if.valid && chr_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                           idle_table  [4];
        int                           stall_table [4];
        longint unsigned              span;
        logic [sdaf_pkg::VALUE_W-1:0] mag;
        logic                         neg;
        logic [sdaf_pkg::PAD_W-1:0]   width;

        idle_table  = '{0, 72, 0, 36};
        stall_table = '{0, 0, 72, 36};
        i_rst_n             = 1'b0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numbers: zero, extremes, short decimals and every pad width corner.
        add_number(32'sd0, 1'b0, 1'b0, 4'd1);
        add_number(32'sd0, 1'b1, 1'b0, 4'd1);
        add_number(32'sh8000_0000, 1'b0, 1'b0, 4'd1);
        add_number(32'sh8000_0000, 1'b1, 1'b0, 4'd1);
        add_number(32'sh7FFF_FFFF, 1'b0, 1'b0, 4'd1);
        add_number(32'sh7FFF_FFFF, 1'b1, 1'b0, 4'd1);
        add_number(-32'sd1, 1'b0, 1'b0, 4'd1);
        add_number(-32'sd5, 1'b1, 1'b0, 4'd1);
        add_number(32'sd5, 1'b1, 1'b0, 4'd1);
        add_number(32'sd9, 1'b0, 1'b0, 4'd1);
        add_number(32'sd10, 1'b1, 1'b0, 4'd1);
        add_number(-32'sd10, 1'b1, 1'b0, 4'd1);
        add_number(32'sd1234567890, 1'b0, 1'b0, 4'd1);
        add_number(-32'sd1000000000, 1'b0, 1'b0, 4'd1);
        add_number(-32'sd1999999999, 1'b1, 1'b0, 4'd1);
        add_number(32'sd42, 1'b0, 1'b1, 4'd0);
        add_number(32'sd99, 1'b0, 1'b1, 4'd1);
        add_number(32'sd7, 1'b0, 1'b1, 4'd3);
        add_number(-32'sd12345, 1'b0, 1'b1, 4'd5);
        add_number(32'sh8000_0000, 1'b0, 1'b1, 4'd10);
        add_number(32'sh7FFF_FFFF, 1'b1, 1'b1, 4'd11);
        add_number(-32'sd1, 1'b1, 1'b1, 4'd15);
        add_number(32'sd0, 1'b0, 1'b1, 4'd10);
        wait_for_text_done();

        // Random numbers, one batch per pacing phase; each batch drains before the next.
        for (int ph = 0; ph < 8; ph++) begin
            sender_idle_pct    = idle_table[ph % 4];
            receiver_stall_pct = stall_table[ph % 4];
            for (int i = 0; i < PHASE_NUMBERS; i++) begin
                neg = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0: mag = $urandom;
                    1: begin
                        case ($urandom_range(3))
                            0: mag = 32'h8000_0000;
                            1: mag = 32'h7FFF_FFFF;
                            2: mag = 32'd0;
                            default: mag = 32'd1;
                        endcase
                    end
                    default: begin
                        // Pick a digit count first so short and long texts both show up.
                        span = 1;
                        repeat ($urandom_range(1, 10)) span = span * 10;
                        mag = sdaf_pkg::VALUE_W'(longint'($urandom) % span);
                    end
                endcase
                width = ($urandom_range(4) == 0)
                      ? sdaf_pkg::PAD_W'($urandom_range(15))
                      : sdaf_pkg::PAD_W'($urandom_range(1, sdaf_pkg::MAX_DIGITS));
                add_number(neg ? -mag : mag, 1'($urandom_range(1)),
                           ($urandom_range(9) < 3), width);
            end
            wait_for_text_done();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Formatted %0d numbers into %0d checked characters, covering integer,",
                 numbers_sent, chars_checked);
        $display("decimal and padded modes under four sender and receiver pacing mixes.");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdaf_pkg.sv
rtl/sdaf_in_if.sv
rtl/sdaf_out_if.sv
rtl/sdaf_dd.sv
rtl/signed_decimal_ascii_formatter.sv
rtl/sdaf_checker.sv
tb/sv/signed_decimal_ascii_formatter_tb.sv
